>>> sv/ptt_pkg.sv
package ptt_pkg;

   localparam int IdW      = 16;
   localparam int DurW     = 16;
   localparam int TimeW    = 32;
   localparam int TimeoutW = 16;
   localparam int ModeW    = 2;
   localparam int KindW    = 3;

   localparam logic [TimeoutW-1:0] TimeoutReset = 16'd15;

   typedef enum logic [ModeW-1:0] {
      MODE_ADD      = 2'd0,
      MODE_COMPLETE = 2'd1,
      MODE_TICK     = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [KindW-1:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_DONE      = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_RETRY     = 3'd4,
      KIND_NO_EXPIRY = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [IdW-1:0]   task_id;
      logic [DurW-1:0]  duration;
      logic [TimeW-1:0] start;
   } slot_type;

   typedef struct packed {
      kind_type        kind;
      logic [IdW-1:0]  task_id;
      logic [DurW-1:0] duration;
      logic            last;
   } rsp_type;

endpackage

>>> sv/ptt_if.sv
interface ptt_req_if import ptt_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ModeW-1:0]    mode;
   logic [IdW-1:0]      task_id;
   logic [DurW-1:0]     task_duration;

   modport source (output valid, mode, task_id, task_duration, input ready);
   modport sink   (input valid, mode, task_id, task_duration, output ready);
endinterface

interface ptt_rsp_if import ptt_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KindW-1:0]    kind;
   logic [IdW-1:0]      out_task_id;
   logic [DurW-1:0]     out_duration;
   logic                last;

   modport source (output valid, kind, out_task_id, out_duration, last, input ready);
   modport sink   (input valid, kind, out_task_id, out_duration, last, output ready);
endinterface

interface ptt_csr_if import ptt_pkg::*;;
   logic                valid;
   logic                ready;
   logic [TimeoutW-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> sv/ptt_ram.sv
module ptt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pending_task_timeout_table.sv
// Pending task table with timeout and retry.
// req_ch: one beat per command. mode add stores task_id/task_duration in the
//   lowest free slot, complete frees the lowest valid slot with that id, tick
//   advances the second count and retires every slot older than the timeout.
// rsp_ch: add and complete give one beat; a tick gives one retry beat per
//   expired slot in slot order, or one no-expiry beat. last marks the final
//   beat of a command.
// csr_ch: writes timeout_seconds (reset value 15); write only while idle.
// Throughput: one command at a time. Complete and tick read the slot RAM
//   one slot per cycle unless a stalled rsp_ch holds the scan; add searches
//   the valid bits. req_ch.ready returns as soon as the last beat is loaded
//   into the output register, so the next command overlaps its delivery.
// Stall: a stalled rsp_ch freezes the scan on the slot that needs to emit.
// Reset: synchronous; all slots free, second count zero, no clearing pass.
module pending_task_timeout_table import ptt_pkg::*; #(
   parameter int SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   ptt_req_if.sink    req_ch,
   ptt_rsp_if.source  rsp_ch,
   ptt_csr_if.sink    csr_ch
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] EndPtr = CW'(SLOTS);

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [IdW-1:0]       id_ff, id_in;
   logic [DurW-1:0]      dur_ff, dur_in;
   logic [TimeW-1:0]     sec_ff, sec_in;
   logic [TimeoutW-1:0]  timeout_ff, timeout_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 out_vld_ff, out_vld_in;
   rsp_type              out_ff, out_in;
   logic                 hold_vld_ff, hold_vld_in;
   rsp_type              hold_ff, hold_in;

   logic                 ram_wr, ram_rd;
   slot_type             ram_wdata, cur;
   logic [$bits(slot_type)-1:0] ram_rdata;
   logic [IW-1:0]        ptr_idx;
   logic [TimeW-1:0]     elapsed;
   logic                 out_busy, req_accept, hit_done, hit_exp, stall;

   ptt_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ptr_idx),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd),
      .rd_addr (ptr_idx),
      .rd_data (ram_rdata)
   );

   assign ptr_idx    = ptr_ff[IW-1:0];
   assign cur        = slot_type'(ram_rdata);
   assign ram_wdata  = '{task_id: id_ff, duration: dur_ff, start: sec_ff};
   assign elapsed    = sec_ff - cur.start;
   assign out_busy   = out_vld_ff & ~rsp_ch.ready;
   assign req_accept = req_ch.valid & req_ch.ready;
   assign hit_done   = cmp_vld_ff && mode_ff == MODE_COMPLETE && valid_ff[cmp_idx_ff]
                       && cur.task_id == id_ff;
   assign hit_exp    = cmp_vld_ff && mode_ff == MODE_TICK && valid_ff[cmp_idx_ff]
                       && elapsed > {{(TimeW-TimeoutW){1'b0}}, timeout_ff};
   assign stall      = (hit_done | (hit_exp & hold_vld_ff)) & out_busy;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.kind         = out_ff.kind;
   assign rsp_ch.out_task_id  = out_ff.task_id;
   assign rsp_ch.out_duration = out_ff.duration;
   assign rsp_ch.last         = out_ff.last;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      id_in       = id_ff;
      dur_in      = dur_ff;
      sec_in      = sec_ff;
      timeout_in  = timeout_ff;
      valid_in    = valid_ff;
      ptr_in      = ptr_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      out_vld_in  = out_busy;
      out_in      = out_ff;
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      ram_wr      = 1'b0;
      ram_rd      = 1'b0;

      if (csr_ch.valid & csr_ch.ready) begin
         timeout_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in    = mode_type'(req_ch.mode);
               id_in      = req_ch.task_id;
               dur_in     = req_ch.task_duration;
               ptr_in     = '0;
               cmp_vld_in = 1'b0;
               unique case (mode_type'(req_ch.mode))
                  MODE_ADD:      state_in = ST_ADD;
                  MODE_COMPLETE: state_in = ST_SCAN;
                  MODE_TICK: begin
                     sec_in   = sec_ff + TimeW'(1);
                     state_in = ST_SCAN;
                  end
                  MODE_NONE:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (ptr_ff == EndPtr) begin
               if (!out_busy) begin
                  out_vld_in = 1'b1;
                  out_in     = '{KIND_FULL, id_ff, '0, 1'b1};
                  state_in   = ST_IDLE;
               end
            end else if (!valid_ff[ptr_idx]) begin
               if (!out_busy) begin
                  ram_wr            = 1'b1;
                  valid_in[ptr_idx] = 1'b1;
                  out_vld_in        = 1'b1;
                  out_in            = '{KIND_ADDED, id_ff, '0, 1'b1};
                  state_in          = ST_IDLE;
               end
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            if (hit_done) begin
               if (!out_busy) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  out_vld_in           = 1'b1;
                  out_in               = '{KIND_DONE, id_ff, '0, 1'b1};
                  cmp_vld_in           = 1'b0;
                  state_in             = ST_IDLE;
               end
            end else if (!stall) begin
               if (hit_exp) begin
                  // previous retry is known not to be final; the new one waits
                  valid_in[cmp_idx_ff] = 1'b0;
                  if (hold_vld_ff) begin
                     out_vld_in = 1'b1;
                     out_in     = hold_ff;
                  end
                  hold_vld_in = 1'b1;
                  hold_in     = '{KIND_RETRY, cur.task_id, cur.duration, 1'b0};
               end
               if (!cmp_vld_ff && ptr_ff == EndPtr) begin
                  if (!out_busy) begin
                     out_vld_in = 1'b1;
                     if (mode_ff == MODE_TICK && hold_vld_ff) begin
                        out_in      = hold_ff;
                        out_in.last = 1'b1;
                        hold_vld_in = 1'b0;
                     end else if (mode_ff == MODE_TICK) begin
                        out_in = '{KIND_NO_EXPIRY, '0, '0, 1'b1};
                     end else begin
                        out_in = '{KIND_NOT_FOUND, id_ff, '0, 1'b1};
                     end
                     state_in = ST_IDLE;
                  end
               end else if (ptr_ff != EndPtr) begin
                  ram_rd     = 1'b1;
                  ptr_in     = ptr_ff + CW'(1);
                  cmp_vld_in = 1'b1;
                  cmp_idx_in = ptr_idx;
               end else begin
                  cmp_vld_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sec_ff      <= '0;
         timeout_ff  <= TimeoutReset;
         valid_ff    <= '0;
         ptr_ff      <= '0;
         cmp_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sec_ff      <= sec_in;
         timeout_ff  <= timeout_in;
         valid_ff    <= valid_in;
         ptr_ff      <= ptr_in;
         cmp_vld_ff  <= cmp_vld_in;
         out_vld_ff  <= out_vld_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      id_ff      <= id_in;
      dur_ff     <= dur_in;
      cmp_idx_ff <= cmp_idx_in;
      out_ff     <= out_in;
      hold_ff    <= hold_in;
   end

endmodule

>>> sv/ptt_checker.sv
module ptt_checker import ptt_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [ModeW-1:0]    req_mode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [KindW-1:0]    rsp_kind,
   input logic [IdW-1:0]      rsp_task_id,
   input logic [DurW-1:0]     rsp_duration,
   input logic                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_task_id)
         && $stable(rsp_duration) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != MODE_NONE |=> !req_ready)
      else $error("new command taken while previous one in progress");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= KIND_NO_EXPIRY)
      else $error("undefined result kind");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_RETRY |-> rsp_last && rsp_duration == '0)
      else $error("non-retry beat without last or with duration");

endmodule

bind pending_task_timeout_table ptt_checker u_ptt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_mode     (req_ch.mode),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_task_id  (rsp_ch.out_task_id),
   .rsp_duration (rsp_ch.out_duration),
   .rsp_last     (rsp_ch.last)
);

>>> tb/testbench.sv
module testbench;
   import ptt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = 16;
   localparam int SettleCycles = 2 * SLOTS + 8;
   localparam int CycleLimit   = 400000;
   localparam int PhaseItems   = 16;

   class slot_table_model;
      bit                  used[SLOTS];
      logic [IdW-1:0]      ids[SLOTS];
      logic [DurW-1:0]     durs[SLOTS];
      logic [TimeW-1:0]    stamp[SLOTS];
      logic [TimeW-1:0]    now_sec;
      logic [TimeoutW-1:0] limit_sec;
      rsp_type             owed[$];
      int unsigned         tally[8];
      int unsigned         commands;
      int unsigned         beats;
      int unsigned         errors;

      function new();
         foreach (used[i]) used[i] = 1'b0;
         foreach (tally[i]) tally[i] = 0;
         now_sec   = '0;
         limit_sec = TimeoutReset;
         commands  = 0;
         beats     = 0;
         errors    = 0;
      endfunction

      function void owe(kind_type k, logic [IdW-1:0] id, logic [DurW-1:0] dur, logic last);
         rsp_type r;
         r.kind     = k;
         r.task_id  = id;
         r.duration = dur;
         r.last     = last;
         owed.push_back(r);
         tally[k]++;
      endfunction

      function void accept_command(mode_type m, logic [IdW-1:0] id, logic [DurW-1:0] dur);
         int               hit;
         int               n;
         logic [TimeW-1:0] age;
         hit = -1;
         n   = 0;
         commands++;
         case (m)
            MODE_ADD: begin
               for (int i = 0; i < SLOTS && hit < 0; i++)
                  if (!used[i]) hit = i;
               if (hit >= 0) begin
                  used[hit]  = 1'b1;
                  ids[hit]   = id;
                  durs[hit]  = dur;
                  stamp[hit] = now_sec;
                  owe(KIND_ADDED, id, '0, 1'b1);
               end else begin
                  owe(KIND_FULL, id, '0, 1'b1);
               end
            end
            MODE_COMPLETE: begin
               for (int i = 0; i < SLOTS && hit < 0; i++)
                  if (used[i] && ids[i] == id) hit = i;
               if (hit >= 0) begin
                  used[hit] = 1'b0;
                  owe(KIND_DONE, id, '0, 1'b1);
               end else begin
                  owe(KIND_NOT_FOUND, id, '0, 1'b1);
               end
            end
            MODE_TICK: begin
               now_sec = now_sec + 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  age = now_sec - stamp[i];
                  if (used[i] && age > TimeW'(limit_sec)) begin
                     used[i] = 1'b0;
                     owe(KIND_RETRY, ids[i], durs[i], 1'b0);
                     n++;
                  end
               end
               if (n == 0) owe(KIND_NO_EXPIRY, '0, '0, 1'b1);
               else owed[owed.size() - 1].last = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void check_beat(logic [KindW-1:0] k, logic [IdW-1:0] id,
                               logic [DurW-1:0] dur, logic last);
         rsp_type e;
         beats++;
         if (owed.size() == 0) begin
            $error("beat with nothing pending: kind %0d id %h dur %h", k, id, dur);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (k !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, k);
            errors++;
         end
         if (id !== e.task_id) begin
            $error("out_task_id: expected %h, actual %h", e.task_id, id);
            errors++;
         end
         if (dur !== e.duration) begin
            $error("out_duration: expected %h, actual %h", e.duration, dur);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ptt_req_if req_ch();
   ptt_rsp_if rsp_ch();
   ptt_csr_if csr_ch();

   pending_task_timeout_table #(.SLOTS(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   slot_table_model table_model = new();
   int unsigned     burst_left  = 0;
   int unsigned     settings    = 1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("pending_task_timeout_table: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         table_model.check_beat(rsp_ch.kind, rsp_ch.out_task_id, rsp_ch.out_duration,
                                rsp_ch.last);
   end

   // receiver: open stretches, short flicker, occasional long stall
   initial begin
      int unsigned r;
      wait (reset === 1'b0);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            repeat ($urandom_range(20, 60)) begin
               rsp_ch.ready <= 1'b1;
               @(posedge clock);
            end
         end else if (r < 85) begin
            repeat ($urandom_range(1, 4)) begin
               rsp_ch.ready <= 1'b1;
               @(posedge clock);
            end
            repeat ($urandom_range(1, 3)) begin
               rsp_ch.ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            repeat ($urandom_range(8, 40)) begin
               rsp_ch.ready <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_command(mode_type m, logic [IdW-1:0] id, logic [DurW-1:0] dur);
      int unsigned r;
      int unsigned gap;
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= m;
      req_ch.task_id       <= id;
      req_ch.task_duration <= dur;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      table_model.accept_command(m, id, dur);
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 8) burst_left = $urandom_range(10, 30);
         else if (r < 55) gap = 0;
         else if (r < 90) gap = $urandom_range(1, 3);
         else gap = $urandom_range(6, 30);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (table_model.owed.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_timeout(logic [TimeoutW-1:0] value);
      quiesce();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      table_model.limit_sec = value;
      settings++;
   endtask

   task automatic run_phase(int unsigned count);
      int unsigned    done_items;
      int unsigned    r;
      logic [IdW-1:0] live[$];
      logic [IdW-1:0] id;
      mode_type       m;
      done_items = 0;
      while (done_items < count) begin
         r  = $urandom_range(0, 99);
         id = ($urandom_range(0, 9) < 6) ? IdW'($urandom_range(0, 7)) : IdW'($urandom);
         if (r < 38) begin
            m = MODE_ADD;
         end else if (r < 63) begin
            m = MODE_COMPLETE;
            live.delete();
            for (int i = 0; i < SLOTS; i++)
               if (table_model.used[i]) live.push_back(table_model.ids[i]);
            if (live.size() > 0 && $urandom_range(0, 3) != 0)
               id = live[$urandom_range(0, live.size() - 1)];
         end else if (r < 95) begin
            m = MODE_TICK;
         end else begin
            m = MODE_NONE;
         end
         send_command(m, id, DurW'($urandom));
         if (m != MODE_NONE) begin
            done_items++;
            if (done_items == count / 2) quiesce();
         end
      end
   endtask

   initial begin
      logic [TimeoutW-1:0] plan[5];
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_ADD;
      req_ch.task_id       = '0;
      req_ch.task_duration = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.data          = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset timeout: extremes, duplicates, misses, ignored mode, then fill
      send_command(MODE_ADD, 16'h0000, 16'h0000);
      send_command(MODE_ADD, 16'hFFFF, 16'hFFFF);
      send_command(MODE_ADD, 16'hFFFF, 16'h1234);
      send_command(MODE_COMPLETE, 16'hFFFF, 16'h0000);
      send_command(MODE_COMPLETE, 16'hFFFF, 16'hFFFF);
      send_command(MODE_COMPLETE, 16'hFFFF, 16'h0000);
      send_command(MODE_TICK, 16'hFFFF, 16'hFFFF);
      send_command(MODE_NONE, 16'hAAAA, 16'h5555);
      send_command(MODE_ADD, 16'hA5C3, 16'h3C5A);
      for (int i = 0; i < SLOTS - 2; i++)
         send_command(MODE_ADD, IdW'(16'h0100 + i), DurW'(~i));
      send_command(MODE_ADD, 16'h7E7E, 16'h8181);

      // zero timeout: whole table retires on one tick
      write_timeout(16'd0);
      send_command(MODE_TICK, 16'h0000, 16'h0000);
      send_command(MODE_TICK, 16'h0000, 16'h0000);

      plan[0] = 16'd2;
      plan[1] = 16'hFFFF;
      plan[2] = TimeoutW'($urandom_range(0, 6));
      plan[3] = 16'd1;
      plan[4] = TimeoutW'($urandom_range(3, 10));
      foreach (plan[p]) begin
         write_timeout(plan[p]);
         run_phase(PhaseItems);
      end

      quiesce();
      $display("run covered %0d commands and %0d result beats over %0d timeout settings",
               table_model.commands, table_model.beats, settings);
      $display("added %0d, full %0d, completed %0d, not found %0d, retried %0d, idle ticks %0d",
               table_model.tally[KIND_ADDED], table_model.tally[KIND_FULL],
               table_model.tally[KIND_DONE], table_model.tally[KIND_NOT_FOUND],
               table_model.tally[KIND_RETRY], table_model.tally[KIND_NO_EXPIRY]);
      if (table_model.errors == 0 && table_model.owed.size() == 0)
         $display("pending_task_timeout_table: match");
      else
         $display("pending_task_timeout_table: mismatch");
      $finish;
   end

endmodule
